FILE: design/fqs_pkg.sv
package fqs_pkg;

	localparam logic [2:0] FUNC_PUSH   = 3'd0;
	localparam logic [2:0] FUNC_POP    = 3'd1;
	localparam logic [2:0] FUNC_PEEK_F = 3'd2;
	localparam logic [2:0] FUNC_PEEK_B = 3'd3;
	localparam logic [2:0] FUNC_SEARCH = 3'd4;
	localparam logic [2:0] FUNC_CLEAR  = 3'd5;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic               found;
		logic [4:0]         occupancy;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic srch_step;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic srch;
		logic srch_done;
	} sts_t;

endpackage

FILE: design/fqs_ctrl.sv
module fqs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  fqs_pkg::sts_t sts,
	output fqs_pkg::cmd_t cmd
);
	import fqs_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.srch ? ST_SEARCH : ST_RESULT;
			end
			ST_SEARCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/fqs_dp.sv
module fqs_dp #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fqs_pkg::req_t req,
	input  fqs_pkg::cmd_t cmd,
	output fqs_pkg::sts_t sts,
	output fqs_pkg::rsp_t rsp
);
	import fqs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [31:0]   mem [DEPTH];

	logic [2:0]    op_q;
	logic [31:0]   val_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] left_q;
	logic [31:0]   rd_data_q;
	logic [1:0]    status_q;
	logic          found_q;
	logic          peek_ok_q;
	rsp_t          rsp_q;

	logic          full;
	logic          empty;
	logic          hit;
	logic [AW-1:0] head_next;
	logic [AW-1:0] tail_next;
	logic [AW-1:0] tail_prev;
	logic [AW-1:0] pos_next;
	logic [AW-1:0] rd_addr;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_next = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST : tail_q - 1'b1;
	assign pos_next  = (pos_q == LAST) ? '0 : pos_q + 1'b1;
	assign hit       = (rd_data_q == val_q);

	assign sts.srch      = (op_q == FUNC_SEARCH) && !empty;
	assign sts.srch_done = hit || (left_q == CW'(1));

	// The exec cycle reads the head (or the newest entry for peek back); a
	// search then walks forward from there one entry per cycle.
	always_comb begin
		if (cmd.exec) begin
			rd_addr = (op_q == FUNC_PEEK_B) ? tail_prev : head_q;
		end else begin
			rd_addr = pos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (op_q == FUNC_PUSH) && !full) begin
			mem[tail_q] <= val_q;
		end
		if (cmd.exec || cmd.srch_step) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.func;
			val_q <= req.value;
		end
		if (cmd.exec) begin
			pos_q  <= head_next;
			left_q <= count_q;
		end else if (cmd.srch_step) begin
			pos_q  <= pos_next;
			left_q <= left_q - 1'b1;
		end
		if (cmd.emit) begin
			rsp_q.status    <= status_q;
			rsp_q.data      <= peek_ok_q ? rd_data_q : '0;
			rsp_q.found     <= found_q;
			rsp_q.occupancy <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			status_q  <= STATUS_OK;
			found_q   <= 1'b0;
			peek_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			status_q  <= STATUS_OK;
			found_q   <= 1'b0;
			peek_ok_q <= 1'b0;
			unique case (op_q)
				FUNC_PUSH: begin
					if (full) begin
						status_q <= STATUS_FULL;
					end else begin
						tail_q  <= tail_next;
						count_q <= count_q + 1'b1;
					end
				end
				FUNC_POP: begin
					if (empty) begin
						status_q <= STATUS_EMPTY;
					end else begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
					end
				end
				FUNC_PEEK_F, FUNC_PEEK_B: begin
					if (empty) begin
						status_q <= STATUS_EMPTY;
					end else begin
						peek_ok_q <= 1'b1;
					end
				end
				FUNC_CLEAR: begin
					head_q  <= '0;
					tail_q  <= '0;
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.srch_step && hit) begin
			found_q <= 1'b1;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: design/fifo_queue_with_search_core.sv
// Channel   Valid       Stall       Payload   Direction
// request   req_valid   req_stall   req       into the block
// response  rsp_valid   rsp_stall   rsp       out of the block
//
// One item is worked on at a time: it is loaded, executed and then emitted.
// Search walks the stored entries through the single memory read port, one
// entry per cycle, and stops at the first match or after the last entry.
// After reset the queue is empty; the entry memory is not cleared.
// A stalled response waits in the output register while the next item is taken.
module fifo_queue_with_search_core #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fqs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fqs_pkg::rsp_t rsp
);
	import fqs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fqs_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: tb/sv/fifo_queue_with_search_core_tb.sv
`timescale 1ns / 100ps

module fifo_queue_with_search_core_tb;
	import fqs_pkg::*;

	localparam int DEPTH = 16;
	// Function codes the block does not define; they must leave the queue alone.
	localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;

	// Shadow copy of the queue, advanced once per accepted item.
	logic signed [31:0] mirror_entries [DEPTH];
	int unsigned mirror_head = 0;
	int unsigned mirror_tail = 0;
	int unsigned mirror_count = 0;

	rsp_t due_replies [$];

	fifo_queue_with_search_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic rsp_t apply_queue_op(input req_t op);
		rsp_t res;
		int unsigned slot;
		res = '0;
		res.status = STATUS_OK;
		case (op.func)
			FUNC_PUSH: begin
				if (mirror_count >= DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					mirror_entries[mirror_tail] = op.value;
					mirror_tail = (mirror_tail + 1) % DEPTH;
					mirror_count++;
				end
			end
			FUNC_POP: begin
				if (mirror_count == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					mirror_head = (mirror_head + 1) % DEPTH;
					mirror_count--;
				end
			end
			FUNC_PEEK_F: begin
				if (mirror_count == 0)
					res.status = STATUS_EMPTY;
				else
					res.data = mirror_entries[mirror_head];
			end
			FUNC_PEEK_B: begin
				if (mirror_count == 0)
					res.status = STATUS_EMPTY;
				else
					res.data = mirror_entries[(mirror_tail + DEPTH - 1) % DEPTH];
			end
			FUNC_SEARCH: begin
				slot = mirror_head;
				for (int i = 0; i < mirror_count; i++) begin
					if (mirror_entries[slot] == op.value)
						res.found = 1'b1;
					slot = (slot + 1) % DEPTH;
				end
			end
			FUNC_CLEAR: begin
				mirror_head = 0;
				mirror_tail = 0;
				mirror_count = 0;
			end
			default: begin
			end
		endcase
		res.occupancy = 5'(mirror_count);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Outputs are compared at the falling edge before the edge that accepts them.
	initial begin : reply_checker
		rsp_t want;
		forever begin
			@(negedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (due_replies.size() == 0) begin
					report_mismatch("response with no item outstanding", rsp.data, 32'd0);
				end else begin
					want = due_replies.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.data !== want.data)
						report_mismatch("data", rsp.data, want.data);
					if (rsp.found !== want.found)
						report_mismatch("found", 32'(rsp.found), 32'(want.found));
					if (rsp.occupancy !== want.occupancy)
						report_mismatch("occupancy", 32'(rsp.occupancy),
							32'(want.occupancy));
				end
			end
		end
	end

	task automatic send_op(input logic [2:0] func, input logic signed [31:0] value);
		req_t item;
		bit took;
		item.func = func;
		item.value = value;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			req.value <= $urandom;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do begin
			@(negedge clk);
			took = !req_stall;
			@(posedge clk);
		end while (!took);
		due_replies.push_back(apply_queue_op(item));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (due_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(3))
			0: return 32'($signed($urandom_range(8)) - 4);
			1: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_queue();
		send_op(FUNC_POP, $urandom);
		send_op(FUNC_PEEK_F, $urandom);
		send_op(FUNC_PEEK_B, $urandom);
		send_op(FUNC_SEARCH, -1);
		send_op(FUNC_SPARE_6, $urandom);
		send_op(FUNC_SPARE_7, $urandom);
	endtask

	task automatic test_fill_to_full();
		send_op(FUNC_PUSH, 32'sh8000_0000);
		send_op(FUNC_PUSH, 32'sh7fff_ffff);
		send_op(FUNC_PUSH, 0);
		send_op(FUNC_PUSH, -1);
		for (int i = 4; i < DEPTH; i++)
			send_op(FUNC_PUSH, $urandom);
		// One past capacity is refused and must not disturb the contents.
		send_op(FUNC_PUSH, 32'sh1234_5678);
		send_op(FUNC_PEEK_F, $urandom);
		send_op(FUNC_PEEK_B, $urandom);
		send_op(FUNC_SEARCH, 32'sh7fff_ffff);
		send_op(FUNC_POP, $urandom);
		send_op(FUNC_CLEAR, $urandom);
	endtask

	task automatic test_random_traffic(input int n_items, input int send_pct,
			input int recv_pct);
		int push_bias;
		int roll;
		logic [2:0] func;
		logic signed [31:0] val;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		push_bias = 60;
		for (int k = 0; k < n_items; k++) begin
			// Pick filling or draining stretches at random so the queue hits both ends and wraps.
			if (k % 32 == 0)
				push_bias = $urandom_range(1) ? 75 : 30;
			roll = $urandom_range(99);
			val = pick_value();
			if (roll < 2) begin
				func = $urandom_range(1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
			end else if (roll < 3) begin
				func = FUNC_CLEAR;
			end else if ($urandom_range(99) < push_bias) begin
				func = FUNC_PUSH;
			end else begin
				roll = $urandom_range(99);
				if (roll < 40)
					func = FUNC_POP;
				else if (roll < 55)
					func = FUNC_PEEK_F;
				else if (roll < 70)
					func = FUNC_PEEK_B;
				else
					func = FUNC_SEARCH;
			end
			if (func == FUNC_SEARCH && mirror_count != 0 && $urandom_range(1))
				val = mirror_entries[(mirror_head + $urandom_range(mirror_count - 1)) % DEPTH];
			send_op(func, val);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_fill_to_full();
		wait_drained();

		test_random_traffic(175, 32, 66);
		wait_drained();
		test_random_traffic(175, 66, 32);
		wait_drained();
		test_random_traffic(175, 0, 0);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
design/fqs_pkg.sv
design/fqs_ctrl.sv
design/fqs_dp.sv
design/fifo_queue_with_search_core.sv
tb/sv/fifo_queue_with_search_core_tb.sv
